// File: sv/angle_to_sexagesimal_text_unit_defines.svh
// assertion macros for the angle to sexagesimal text unit
// used by modules that carry clk_i and rst_ni; no other dependencies
`ifndef ANGLE_TO_SEXAGESIMAL_TEXT_UNIT_DEFINES_SVH
`define ANGLE_TO_SEXAGESIMAL_TEXT_UNIT_DEFINES_SVH

// property must hold at every clock edge outside reset
`define A2ST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define A2ST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: sv/a2st_pkg.sv
// shared types and constants of the angle to sexagesimal text unit
// no dependencies
`timescale 1ns / 1ps

package a2st_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_HOURS_UNIT     = 3'd0;
  localparam logic [2:0] REG_HALF_RANGE     = 3'd1;
  localparam logic [2:0] REG_SEPARATOR_KIND = 3'd2;
  localparam logic [2:0] REG_FORCE_SIGN     = 3'd3;
  localparam logic [2:0] REG_ZERO_PAD       = 3'd4;
  localparam logic [2:0] REG_UNIT_WIDTH     = 3'd5;
  localparam logic [2:0] REG_DECIMAL_DIGITS = 3'd6;

  // separator kinds
  localparam logic [1:0] SEP_LETTERS = 2'd0;
  localparam logic [1:0] SEP_SPACE   = 2'd1;
  localparam logic [1:0] SEP_COLON   = 2'd2;
  localparam logic [1:0] SEP_NONE    = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_DEC     = 9;

  typedef struct packed {
    logic       hours_unit;
    logic       half_range;
    logic [1:0] separator_kind;
    logic       force_sign;
    logic       zero_pad;
    logic [1:0] unit_width;
    logic [3:0] decimal_digits;
  } cfg_t;

  // register defaults after reset
  localparam cfg_t CFG_RESET = '{hours_unit: 1'b0, half_range: 1'b0,
                                 separator_kind: SEP_LETTERS, force_sign: 1'b0,
                                 zero_pad: 1'b0, unit_width: 2'd3,
                                 decimal_digits: 4'd0};

  // one formatted angle, digits in bcd
  typedef struct packed {
    logic                        negout;
    logic [2:0][3:0]             ud;   // units, index 0 is least significant
    logic [1:0][3:0]             md;
    logic [1:0][3:0]             sd;
    logic [MAX_DEC-1:0][3:0]     dd;   // decimals, index 0 is most significant
  } entry_t;

endpackage

// File: sv/a2st_if.sv
// stream interfaces of the angle to sexagesimal text unit
// depends on nothing
`timescale 1ns / 1ps

interface a2st_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] angle_deg;
  modport source (output valid, output angle_deg, input ready);
  modport sink   (input valid, input angle_deg, output ready);
endinterface

interface a2st_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: sv/a2st_front.sv
// front end: input skid, modulo reduction, unit split, rounding, bcd conversion
// depends on a2st_pkg
`timescale 1ns / 1ps

module a2st_front #(
  parameter int unsigned FRAC_BITS = 44,
  parameter int unsigned INT_BITS  = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  a2st_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [63:0]     in_angle_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output a2st_pkg::entry_t push_data_o
);

  localparam int unsigned WEFF  = (INT_BITS + FRAC_BITS < 64) ? INT_BITS + FRAC_BITS : 64;
  localparam int unsigned IPW   = WEFF - FRAC_BITS;
  localparam int unsigned STEPS = (IPW + 1) / 2;
  localparam int unsigned IMW   = 2 * STEPS;
  localparam int unsigned CW    = $clog2(STEPS) + 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MOD   = 4'd1;
  localparam logic [3:0] ST_RED1  = 4'd2;
  localparam logic [3:0] ST_RED2  = 4'd3;
  localparam logic [3:0] ST_SPLIT = 4'd4;
  localparam logic [3:0] ST_SEC   = 4'd5;
  localparam logic [3:0] ST_DEC   = 4'd6;
  localparam logic [3:0] ST_RND   = 4'd7;
  localparam logic [3:0] ST_CONV  = 4'd8;
  localparam logic [3:0] ST_PUSH  = 4'd9;

  logic                 buf_full_q, buf_full_d;
  logic [63:0]          buf_q;
  logic [3:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [3:0]           dcnt_q, dcnt_d;
  logic                 neg_q, neg_d;
  logic [IMW-1:0]       im_q, im_d;
  logic [FRAC_BITS-1:0] mf_q, mf_d;
  logic [8:0]           rem_q, rem_d;
  logic [8:0]           ai_q, ai_d;
  logic [FRAC_BITS-1:0] af_q, af_d;
  logic                 negout_q, negout_d;
  logic [8:0]           units_q, units_d;
  logic [5:0]           mins_q, mins_d;
  logic [5:0]           sec_q, sec_d;
  logic [FRAC_BITS-1:0] fr_q, fr_d;
  logic [a2st_pkg::MAX_DEC-1:0][3:0] dd_q, dd_d;
  a2st_pkg::entry_t     ent_q, ent_d;

  logic [3:0] ddig;
  logic       branch_a;

  // accepting while the previous angle is still in work
  assign in_ready_o   = !buf_full_q;
  assign push_valid_o = (state_q == ST_PUSH);
  assign push_data_o  = ent_q;

  assign ddig     = (cfg_i.decimal_digits > 4'd9) ? 4'd9 : cfg_i.decimal_digits;
  assign branch_a = !cfg_i.half_range || (cfg_i.unit_width == 2'd3);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_full_q <= 1'b0;
      state_q    <= ST_IDLE;
    end else begin
      buf_full_q <= buf_full_d;
      state_q    <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      buf_q <= in_angle_i;
    end
    cnt_q    <= cnt_d;
    dcnt_q   <= dcnt_d;
    neg_q    <= neg_d;
    im_q     <= im_d;
    mf_q     <= mf_d;
    rem_q    <= rem_d;
    ai_q     <= ai_d;
    af_q     <= af_d;
    negout_q <= negout_d;
    units_q  <= units_d;
    mins_q   <= mins_d;
    sec_q    <= sec_d;
    fr_q     <= fr_d;
    dd_q     <= dd_d;
    ent_q    <= ent_d;
  end

  // sequencer
  always_comb begin
    logic signed [WEFF-1:0] ts;
    logic [63:0]            u;
    logic [63:0]            mag;
    logic [9:0]             r;
    logic                   nz;
    logic [21:0]            hprod;
    logic [3:0]             base;
    logic [5:0]             scale;
    logic [FRAC_BITS+5:0]   p;
    logic [FRAC_BITS+5:0]   p2;
    logic [FRAC_BITS+3:0]   p3;
    logic                   carry;
    logic [6:0]             ur;
    logic [1:0]             uh;
    logic [14:0]            tp;
    logic [13:0]            mp;
    logic [3:0]             ut;
    logic [3:0]             mt;
    logic [3:0]             st;

    buf_full_d = buf_full_q || (in_valid_i && in_ready_o);
    state_d    = state_q;
    cnt_d      = cnt_q;
    dcnt_d     = dcnt_q;
    neg_d      = neg_q;
    im_d       = im_q;
    mf_d       = mf_q;
    rem_d      = rem_q;
    ai_d       = ai_q;
    af_d       = af_q;
    negout_d   = negout_q;
    units_d    = units_q;
    mins_d     = mins_q;
    sec_d      = sec_q;
    fr_d       = fr_q;
    dd_d       = dd_q;
    ent_d      = ent_q;

    ts    = buf_q[WEFF-1:0];
    u     = 64'(ts);
    mag   = u[63] ? (64'd0 - u) : u;
    r     = '0;
    nz    = (rem_q != 9'd0) || (mf_q != '0);
    hprod = '0;
    base  = '0;
    scale = '0;
    p     = '0;
    p2    = '0;
    p3    = '0;
    carry = 1'b0;
    ur    = '0;
    uh    = '0;
    tp    = '0;
    mp    = '0;
    ut    = '0;
    mt    = '0;
    st    = '0;

    unique case (state_q)
      // take the buffered angle, sign and magnitude
      ST_IDLE: begin
        if (buf_full_q) begin
          buf_full_d = 1'b0;
          neg_d      = u[63];
          im_d       = IMW'(mag[FRAC_BITS +: IPW]);
          mf_d       = mag[FRAC_BITS-1:0];
          rem_d      = 9'd0;
          cnt_d      = '0;
          state_d    = ST_MOD;
        end
      end
      // integer part modulo 360, two bits a cycle
      ST_MOD: begin
        r = {rem_q, im_q[IMW-1]};
        if (r >= 10'd360) r = r - 10'd360;
        r = {r[8:0], im_q[IMW-2]};
        if (r >= 10'd360) r = r - 10'd360;
        rem_d = r[8:0];
        im_d  = {im_q[IMW-3:0], 2'b00};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) state_d = ST_RED1;
      end
      // fold into the positive range or clamp to 90
      ST_RED1: begin
        if (branch_a) begin
          if (neg_q && nz) begin
            ai_d = 9'd360 - rem_q - {8'd0, (mf_q != '0)};
            af_d = '0 - mf_q;
          end else begin
            ai_d = rem_q;
            af_d = mf_q;
          end
          state_d = ST_RED2;
        end else begin
          if ((rem_q > 9'd90) || ((rem_q == 9'd90) && (mf_q != '0))) begin
            ai_d = 9'd90;
            af_d = '0;
          end else begin
            ai_d = rem_q;
            af_d = mf_q;
          end
          negout_d = neg_q && nz;
          state_d  = ST_SPLIT;
        end
      end
      // signed half range above 180
      ST_RED2: begin
        if (cfg_i.half_range &&
            ((ai_q > 9'd180) || ((ai_q == 9'd180) && (af_q != '0)))) begin
          negout_d = 1'b1;
          ai_d     = 9'd360 - ai_q - {8'd0, (af_q != '0)};
          af_d     = '0 - af_q;
        end else begin
          negout_d = 1'b0;
        end
        state_d = ST_SPLIT;
      end
      // whole units and minutes
      ST_SPLIT: begin
        if (cfg_i.hours_unit) begin
          hprod   = 22'(ai_q) * 22'd4370;
          units_d = 9'(hprod >> 16);
          base    = 4'(ai_q - 9'(units_d * 9'd15));
          scale   = 6'd4;
        end else begin
          units_d = ai_q;
          base    = 4'd0;
          scale   = 6'd60;
        end
        p      = (FRAC_BITS+6)'(af_q) * (FRAC_BITS+6)'(scale);
        mins_d = 6'({base, 2'b00}) + p[FRAC_BITS +: 6];
        if (!cfg_i.hours_unit) mins_d = p[FRAC_BITS +: 6];
        fr_d    = p[FRAC_BITS-1:0];
        state_d = ST_SEC;
      end
      // whole seconds
      ST_SEC: begin
        p2      = (FRAC_BITS+6)'(fr_q) * (FRAC_BITS+6)'(6'd60);
        sec_d   = p2[FRAC_BITS +: 6];
        fr_d    = p2[FRAC_BITS-1:0];
        dcnt_d  = 4'd0;
        state_d = (ddig != 4'd0) ? ST_DEC : ST_RND;
      end
      // one decimal digit a cycle
      ST_DEC: begin
        p3             = (FRAC_BITS+4)'(fr_q) * (FRAC_BITS+4)'(4'd10);
        dd_d[dcnt_q]   = p3[FRAC_BITS +: 4];
        fr_d           = p3[FRAC_BITS-1:0];
        dcnt_d         = dcnt_q + 4'd1;
        if (dcnt_q == ddig - 4'd1) state_d = ST_RND;
      end
      // round half up, carry through decimals, seconds, minutes, units
      ST_RND: begin
        if (fr_q[FRAC_BITS-1]) begin
          carry = 1'b1;
          for (int i = a2st_pkg::MAX_DEC - 1; i >= 0; i--) begin
            if ((4'(i) < ddig) && carry) begin
              if (dd_q[i] == 4'd9) begin
                dd_d[i] = 4'd0;
              end else begin
                dd_d[i] = dd_q[i] + 4'd1;
                carry   = 1'b0;
              end
            end
          end
          if (carry) begin
            if (sec_q == 6'd59) begin
              sec_d = 6'd0;
              if (mins_q == 6'd59) begin
                mins_d  = 6'd0;
                units_d = units_q + 9'd1;
              end else begin
                mins_d = mins_q + 6'd1;
              end
            end else begin
              sec_d = sec_q + 6'd1;
            end
          end
        end
        state_d = ST_CONV;
      end
      // binary to bcd
      ST_CONV: begin
        if (units_q >= 9'd300)      uh = 2'd3;
        else if (units_q >= 9'd200) uh = 2'd2;
        else if (units_q >= 9'd100) uh = 2'd1;
        else                        uh = 2'd0;
        ur = 7'(units_q - 9'(uh) * 9'd100);
        tp = 15'(ur) * 15'd205;
        ut = 4'(tp >> 11);
        mp = 14'(mins_q) * 14'd205;
        mt = 4'(mp >> 11);
        ent_d.negout = negout_q;
        ent_d.ud[2]  = {2'b00, uh};
        ent_d.ud[1]  = ut;
        ent_d.ud[0]  = 4'(ur - 7'(ut) * 7'd10);
        ent_d.md[1]  = mt;
        ent_d.md[0]  = 4'(mins_q - 6'(mt) * 6'd10);
        mp = 14'(sec_q) * 14'd205;
        st = 4'(mp >> 11);
        ent_d.sd[1]  = st;
        ent_d.sd[0]  = 4'(sec_q - 6'(st) * 6'd10);
        ent_d.dd     = dd_q;
        state_d      = ST_PUSH;
      end
      ST_PUSH: begin
        if (push_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/a2st_queue.sv
// two-entry queue between the front end and the text emitter
// depends on a2st_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "angle_to_sexagesimal_text_unit_defines.svh"

module a2st_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  a2st_pkg::entry_t push_data_i,
  output logic             head_valid_o,
  output a2st_pkg::entry_t head_data_o,
  input  logic             pop_i
);

  a2st_pkg::entry_t mem_q [a2st_pkg::QUEUE_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign push_ready_o = (cnt_q != 2'(a2st_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_data_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;

  // pointers and fill count
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  `A2ST_NEVER(a_cnt_range, cnt_q > 2'(a2st_pkg::QUEUE_DEPTH), "queue count overflow")
  `A2ST_ASSERT(a_pop_nonempty, pop_i |-> cnt_q != 2'd0, "pop from empty queue")
  `A2ST_ASSERT(a_ptr_track, (cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q), "pointers out of step")

endmodule

// File: sv/a2st_back.sv
// text emitter: walks the fields of one entry and drives one character a cycle unless stalled
// depends on a2st_pkg
`timescale 1ns / 1ps

module a2st_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  a2st_pkg::cfg_t   cfg_i,
  input  logic             head_valid_i,
  input  a2st_pkg::entry_t head_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             out_last_o
);

  localparam int unsigned SEG_COUNT = 9;
  localparam logic [3:0] SEG_SIGN  = 4'd0;
  localparam logic [3:0] SEG_UNITS = 4'd1;
  localparam logic [3:0] SEG_SEP1  = 4'd2;
  localparam logic [3:0] SEG_MINS  = 4'd3;
  localparam logic [3:0] SEG_SEP2  = 4'd4;
  localparam logic [3:0] SEG_SECS  = 4'd5;
  localparam logic [3:0] SEG_DOT   = 4'd6;
  localparam logic [3:0] SEG_DEC   = 4'd7;
  localparam logic [3:0] SEG_UNIT  = 4'd8;

  logic [3:0] seg_q, seg_d;
  logic [3:0] pos_q, pos_d;
  logic       ov_q, ov_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;

  logic [3:0] seg_len [SEG_COUNT];
  logic [3:0] cur;
  logic       more;
  logic       emit;
  logic       last;
  logic [7:0] ch;

  // padded digit field, position counted from the left
  function automatic logic [7:0] field_char(input logic [3:0] len, input logic [3:0] p,
                                            input logic [1:0] n, input logic [2:0][3:0] dig,
                                            input logic [7:0] pad);
    logic [3:0] idx;
    idx = len - 4'd1 - p;
    if (idx >= {2'b00, n}) return pad;
    return 8'h30 + {4'h0, dig[idx[1:0]]};
  endfunction

  function automatic logic [3:0] max4(input logic [3:0] a, input logic [3:0] b);
    return (a > b) ? a : b;
  endfunction

  // field lengths of the head entry
  always_comb begin
    logic [3:0] adig, wu, wm, ddig;
    logic [1:0] nu, nm, ns;
    logic       wide;
    adig = (cfg_i.unit_width < 2'd2) ? 4'd1 : {2'b00, cfg_i.unit_width};
    wide = cfg_i.zero_pad || (cfg_i.separator_kind == a2st_pkg::SEP_SPACE);
    wu   = wide ? adig : 4'd1;
    wm   = wide ? 4'd2 : 4'd1;
    ddig = (cfg_i.decimal_digits > 4'd9) ? 4'd9 : cfg_i.decimal_digits;
    nu   = (head_data_i.ud[2] != 4'd0) ? 2'd3 : (head_data_i.ud[1] != 4'd0) ? 2'd2 : 2'd1;
    nm   = (head_data_i.md[1] != 4'd0) ? 2'd2 : 2'd1;
    ns   = (head_data_i.sd[1] != 4'd0) ? 2'd2 : 2'd1;
    seg_len[SEG_SIGN]  = (head_data_i.negout || cfg_i.force_sign) ? 4'd1 : 4'd0;
    seg_len[SEG_UNITS] = max4(wu, {2'b00, nu});
    seg_len[SEG_SEP1]  = (cfg_i.separator_kind != a2st_pkg::SEP_NONE) ? 4'd1 : 4'd0;
    seg_len[SEG_MINS]  = max4(wm, {2'b00, nm});
    seg_len[SEG_SEP2]  = (cfg_i.separator_kind != a2st_pkg::SEP_NONE) ? 4'd1 : 4'd0;
    seg_len[SEG_SECS]  = max4(wm, {2'b00, ns});
    seg_len[SEG_DOT]   = (ddig != 4'd0) ? 4'd1 : 4'd0;
    seg_len[SEG_DEC]   = ddig;
    seg_len[SEG_UNIT]  = (cfg_i.separator_kind == a2st_pkg::SEP_LETTERS) ? 4'd1 : 4'd0;
  end

  // skip empty fields; find whether any field follows
  always_comb begin
    cur  = SEG_UNITS;
    more = 1'b0;
    for (int i = SEG_COUNT - 1; i >= 0; i--) begin
      if ((4'(i) >= seg_q) && (seg_len[i] != 4'd0)) cur = 4'(i);
    end
    for (int j = 0; j < SEG_COUNT; j++) begin
      if ((4'(j) > cur) && (seg_len[j] != 4'd0)) more = 1'b1;
    end
  end

  // character of the current position
  always_comb begin
    logic [7:0] pad;
    logic [7:0] sep;
    logic [7:0] letter;
    pad    = cfg_i.zero_pad ? 8'h30 : 8'h20;
    letter = cfg_i.hours_unit ? 8'h68 : 8'h64;
    unique case (cfg_i.separator_kind)
      a2st_pkg::SEP_LETTERS: sep = (cur == SEG_SEP1) ? letter : 8'h6d;
      a2st_pkg::SEP_SPACE:   sep = 8'h20;
      a2st_pkg::SEP_COLON:   sep = 8'h3a;
      default:               sep = 8'h20;
    endcase
    unique case (cur)
      SEG_SIGN:  ch = head_data_i.negout ? 8'h2d : 8'h2b;
      SEG_UNITS: ch = field_char(seg_len[SEG_UNITS], pos_q, seg_len[SEG_UNITS] > 4'd2 &&
                                 head_data_i.ud[2] != 4'd0 ? 2'd3 :
                                 head_data_i.ud[2] != 4'd0 ? 2'd3 :
                                 head_data_i.ud[1] != 4'd0 ? 2'd2 : 2'd1,
                                 head_data_i.ud, pad);
      SEG_SEP1:  ch = sep;
      SEG_MINS:  ch = field_char(seg_len[SEG_MINS], pos_q,
                                 head_data_i.md[1] != 4'd0 ? 2'd2 : 2'd1,
                                 {4'h0, head_data_i.md}, pad);
      SEG_SEP2:  ch = sep;
      SEG_SECS:  ch = field_char(seg_len[SEG_SECS], pos_q,
                                 head_data_i.sd[1] != 4'd0 ? 2'd2 : 2'd1,
                                 {4'h0, head_data_i.sd}, pad);
      SEG_DOT:   ch = 8'h2e;
      SEG_DEC:   ch = (pos_q < 4'(a2st_pkg::MAX_DEC)) ?
                      8'h30 + {4'h0, head_data_i.dd[pos_q]} : 8'h30;
      SEG_UNIT:  ch = 8'h73;
      default:   ch = 8'h20;
    endcase
  end

  assign emit  = head_valid_i && (!ov_q || out_ready_i);
  assign last  = ((pos_q + 4'd1) >= seg_len[cur]) && !more;
  assign pop_o = emit && last;

  // field walk and output register
  always_comb begin
    seg_d  = seg_q;
    pos_d  = pos_q;
    ov_d   = ov_q && !out_ready_i;
    char_d = char_q;
    last_d = last_q;
    if (emit) begin
      ov_d   = 1'b1;
      char_d = ch;
      last_d = last;
      if (last) begin
        seg_d = SEG_SIGN;
        pos_d = 4'd0;
      end else if ((pos_q + 4'd1) >= seg_len[cur]) begin
        seg_d = cur + 4'd1;
        pos_d = 4'd0;
      end else begin
        seg_d = cur;
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SEG_SIGN;
      pos_q <= 4'd0;
      ov_q  <= 1'b0;
    end else begin
      seg_q <= seg_d;
      pos_q <= pos_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

// File: sv/angle_to_sexagesimal_text_unit.sv
// top level of the angle to sexagesimal text unit
// depends on a2st_pkg, a2st_if, a2st_front, a2st_queue and a2st_back
//
// Usage: in_i carries one signed Q(INT_BITS).(FRAC_BITS) angle in degrees per
// transfer; out_o carries the formatted text one ASCII character per transfer,
// with last_char set on the final character of each angle.
// Format registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// the unit is idle; indexes beyond the register list are ignored.
// Front end: an angle goes from the input buffer through the two-bit-per-cycle
// modulo-360 loop over IPW, the integer width of the angle, then the unit
// split, the one-digit-per-cycle decimal loop, rounding and bcd conversion
// into the queue; clamp-to-90 mode skips the half-range step.
// The first character of an entry is offered from the emitter's output register.
// Throughput: the emitter drives one character per cycle while an entry waits
// and the receiver is ready; an angle has up to 21 characters.
// A second angle waits in the input buffer while the first is in work; a
// two-entry queue lets the front end run ahead of the emitter.
// Reset clears all control state and restores the register defaults.
// When the receiver stalls, the output register holds its character and the
// queue fills; then the input buffer stops taking angles.
`timescale 1ns / 1ps

module angle_to_sexagesimal_text_unit #(
  parameter int unsigned FRAC_BITS = 44,
  parameter int unsigned INT_BITS  = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  a2st_in_if.sink     in_i,
  a2st_out_if.source  out_o
);

  a2st_pkg::cfg_t   cfg_q, cfg_d;
  logic             push_valid;
  logic             push_ready;
  a2st_pkg::entry_t push_data;
  logic             head_valid;
  a2st_pkg::entry_t head_data;
  logic             pop;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        a2st_pkg::REG_HOURS_UNIT:     cfg_d.hours_unit     = cfg_wdata_i[0];
        a2st_pkg::REG_HALF_RANGE:     cfg_d.half_range     = cfg_wdata_i[0];
        a2st_pkg::REG_SEPARATOR_KIND: cfg_d.separator_kind = cfg_wdata_i[1:0];
        a2st_pkg::REG_FORCE_SIGN:     cfg_d.force_sign     = cfg_wdata_i[0];
        a2st_pkg::REG_ZERO_PAD:       cfg_d.zero_pad       = cfg_wdata_i[0];
        a2st_pkg::REG_UNIT_WIDTH:     cfg_d.unit_width     = cfg_wdata_i[1:0];
        a2st_pkg::REG_DECIMAL_DIGITS: cfg_d.decimal_digits = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= a2st_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  a2st_front #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_angle_i   (in_i.angle_deg),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  a2st_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .head_valid_o (head_valid),
    .head_data_o  (head_data),
    .pop_i        (pop)
  );

  a2st_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_char_o   (out_o.char_code),
    .out_last_o   (out_o.last_char)
  );

endmodule
